// ===== rtl/core/drp_pkg.sv =====
// DNS reply parser: shared types and constants.
// Parse phase encoding, verdict codes and the parse-to-result status struct.
// No dependencies.
`default_nettype none

package drp_pkg;

  localparam int unsigned HDR_LEN = 12;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_QLAB    = 4'd1,
    PH_QSKIP   = 4'd2,
    PH_QTAIL   = 4'd3,
    PH_ALAB    = 4'd4,
    PH_ASKIP   = 4'd5,
    PH_ATYPE   = 4'd6,
    PH_ATTL    = 4'd7,
    PH_ARDLEN  = 4'd8,
    PH_AADDR   = 4'd9,
    PH_ARDSKIP = 4'd10,
    PH_DONE    = 4'd11
  } phase_t;

  localparam logic [2:0] V_FOUND   = 3'd0;
  localparam logic [2:0] V_SERVERR = 3'd1;
  localparam logic [2:0] V_NOANS   = 3'd2;
  localparam logic [2:0] V_NOADDR  = 3'd3;
  localparam logic [2:0] V_IGNORED = 3'd4;

  // Name length byte that starts a compression pointer has top bits 11.
  localparam logic [1:0] PTR_MARK = 2'b11;
  // Bytes left after a name: type + class, plus one more for a pointer.
  localparam logic [15:0] TAIL_PLAIN = 16'd4;
  localparam logic [15:0] TAIL_PTR   = 16'd5;
  localparam logic [15:0] A_RDLEN    = 16'd4;
  localparam logic [2:0]  TTL_BYTES  = 3'd4;
  localparam logic [2:0]  RDLEN_BYTES = 3'd2;
  localparam logic [2:0]  ADDR_BYTES = 3'd4;

  // Packet status after the current byte has been taken.
  typedef struct packed {
    phase_t      phase;
    logic [15:0] header_id;
    logic [15:0] header_control;
    logic [2:0]  packet_verdict;
    logic [31:0] ttl_accum;
    logic [31:0] address_accum;
  } parse_view_t;

endpackage

`default_nettype wire

// ===== rtl/core/drp_parse_core.sv =====
// DNS reply parser: byte walker. Holds the per-packet parse state and
// computes its update for one byte. Depends on drp_pkg.
`default_nettype none

module drp_parse_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,    // take pkt_byte this cycle
  input  wire logic               last_byte,  // packet ends with this byte
  input  wire logic [7:0]         pkt_byte,
  output drp_pkg::parse_view_t    view        // state after this byte
);
  import drp_pkg::*;

  phase_t      parse_phase,      parse_phase_next;
  logic [15:0] byte_index,       byte_index_next;
  logic [15:0] header_id,        header_id_next;
  logic [15:0] header_control,   header_control_next;
  logic [15:0] questions_left,   questions_left_next;
  logic [15:0] answers_left,     answers_left_next;
  logic [15:0] skip_left,        skip_left_next;
  logic [2:0]  field_byte_count, field_byte_count_next;
  logic [31:0] ttl_accum,        ttl_accum_next;
  logic [15:0] rdata_length,     rdata_length_next;
  logic [31:0] address_accum,    address_accum_next;
  logic [2:0]  packet_verdict,   packet_verdict_next;

  logic [15:0] skip_dec;
  logic [15:0] ans_dec;
  logic [15:0] q_dec;
  logic [2:0]  fbc_inc;
  logic [15:0] rdlen_shift;

  always_comb begin
    skip_dec    = skip_left - 16'd1;
    ans_dec     = (answers_left != 16'd0) ? answers_left - 16'd1 : answers_left;
    q_dec       = questions_left - 16'd1;
    fbc_inc     = field_byte_count + 3'd1;
    rdlen_shift = {rdata_length[7:0], pkt_byte};

    parse_phase_next      = parse_phase;
    header_id_next        = header_id;
    header_control_next   = header_control;
    questions_left_next   = questions_left;
    answers_left_next     = answers_left;
    skip_left_next        = skip_left;
    field_byte_count_next = field_byte_count;
    ttl_accum_next        = ttl_accum;
    rdata_length_next     = rdata_length;
    address_accum_next    = address_accum;
    packet_verdict_next   = packet_verdict;

    unique case (parse_phase)
      PH_HDR: begin
        case (byte_index)
          16'd0: header_id_next      = {pkt_byte, 8'h00};
          16'd1: header_id_next      = {header_id[15:8], pkt_byte};
          16'd2: header_control_next = {pkt_byte, 8'h00};
          16'd3: header_control_next = {header_control[15:8], pkt_byte};
          16'd4: questions_left_next = {pkt_byte, 8'h00};
          16'd5: questions_left_next = {questions_left[15:8], pkt_byte};
          16'd6: answers_left_next   = {pkt_byte, 8'h00};
          16'd7: answers_left_next   = {answers_left[15:8], pkt_byte};
          default: ;
        endcase
        if (byte_index == 16'(HDR_LEN - 1)) begin
          if (answers_left == 16'd0) begin
            packet_verdict_next = V_NOANS;
            parse_phase_next    = PH_DONE;
          end else begin
            parse_phase_next = (questions_left != 16'd0) ? PH_QLAB : PH_ALAB;
          end
        end
      end
      PH_QLAB, PH_ALAB: begin
        if (pkt_byte == 8'h00) begin
          skip_left_next   = TAIL_PLAIN;
          parse_phase_next = (parse_phase == PH_QLAB) ? PH_QTAIL : PH_ATYPE;
        end else if (pkt_byte[7:6] == PTR_MARK) begin
          skip_left_next   = TAIL_PTR;
          parse_phase_next = (parse_phase == PH_QLAB) ? PH_QTAIL : PH_ATYPE;
        end else begin
          skip_left_next   = {8'h00, pkt_byte};
          parse_phase_next = (parse_phase == PH_QLAB) ? PH_QSKIP : PH_ASKIP;
        end
      end
      PH_QSKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 16'd0) parse_phase_next = PH_QLAB;
      end
      PH_ASKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 16'd0) parse_phase_next = PH_ALAB;
      end
      PH_QTAIL: begin
        skip_left_next = skip_dec;
        if (skip_dec == 16'd0) begin
          questions_left_next = q_dec;
          parse_phase_next    = (q_dec != 16'd0) ? PH_QLAB : PH_ALAB;
        end
      end
      PH_ATYPE: begin
        skip_left_next = skip_dec;
        if (skip_dec == 16'd0) begin
          parse_phase_next      = PH_ATTL;
          field_byte_count_next = 3'd0;
          ttl_accum_next        = 32'd0;
        end
      end
      PH_ATTL: begin
        ttl_accum_next        = {ttl_accum[23:0], pkt_byte};
        field_byte_count_next = fbc_inc;
        if (fbc_inc >= TTL_BYTES) begin
          parse_phase_next      = PH_ARDLEN;
          field_byte_count_next = 3'd0;
          rdata_length_next     = 16'd0;
        end
      end
      PH_ARDLEN: begin
        rdata_length_next     = rdlen_shift;
        field_byte_count_next = fbc_inc;
        if (fbc_inc >= RDLEN_BYTES) begin
          field_byte_count_next = 3'd0;
          if (rdlen_shift == A_RDLEN) begin
            parse_phase_next   = PH_AADDR;
            address_accum_next = 32'd0;
          end else if (rdlen_shift == 16'd0) begin
            answers_left_next = ans_dec;
            parse_phase_next  = (ans_dec != 16'd0) ? PH_ALAB : PH_DONE;
          end else begin
            skip_left_next   = rdlen_shift;
            parse_phase_next = PH_ARDSKIP;
          end
        end
      end
      PH_AADDR: begin
        address_accum_next    = {address_accum[23:0], pkt_byte};
        field_byte_count_next = fbc_inc;
        if (fbc_inc >= ADDR_BYTES) begin
          packet_verdict_next = V_FOUND;
          parse_phase_next    = PH_DONE;
        end
      end
      PH_ARDSKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 16'd0) begin
          answers_left_next = ans_dec;
          parse_phase_next  = (ans_dec != 16'd0) ? PH_ALAB : PH_DONE;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    byte_index_next = (byte_index != 16'hFFFF) ? byte_index + 16'd1 : byte_index;
  end

  always_comb begin
    view.phase          = parse_phase_next;
    view.header_id      = header_id_next;
    view.header_control = header_control_next;
    view.packet_verdict = packet_verdict_next;
    view.ttl_accum      = ttl_accum_next;
    view.address_accum  = address_accum_next;
  end

  // Control state; the last byte of a packet returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      parse_phase      <= PH_HDR;
      byte_index       <= 16'd0;
      header_id        <= 16'd0;
      header_control   <= 16'd0;
      questions_left   <= 16'd0;
      answers_left     <= 16'd0;
      skip_left        <= 16'd0;
      field_byte_count <= 3'd0;
      ttl_accum        <= 32'd0;
      rdata_length     <= 16'd0;
      address_accum    <= 32'd0;
      packet_verdict   <= V_NOADDR;
    end else if (advance) begin
      parse_phase      <= parse_phase_next;
      byte_index       <= byte_index_next;
      header_id        <= header_id_next;
      header_control   <= header_control_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      skip_left        <= skip_left_next;
      field_byte_count <= field_byte_count_next;
      ttl_accum        <= ttl_accum_next;
      rdata_length     <= rdata_length_next;
      address_accum    <= address_accum_next;
      packet_verdict   <= packet_verdict_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/drp_result_reg.sv =====
// DNS reply parser: verdict logic and result register.
// Turns the parse status at a last byte into one result item. Depends on drp_pkg.
`default_nettype none

module drp_result_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,        // last byte taken this cycle
  input  wire drp_pkg::parse_view_t view,
  input  wire logic [31:0]        source_ip,
  input  wire logic [31:0]        primary_server_ip,
  input  wire logic [31:0]        backup_server_ip,
  input  wire logic               m_tready,
  output logic                    m_tvalid,
  // {address, ttl_seconds, rcode, query_id, verdict}, verdict in the low bits
  output logic [87:0]             m_tdata
);
  import drp_pkg::*;

  logic [2:0]  verdict;
  logic        ignored;
  logic [31:0] ttl_sel;
  logic [31:0] addr_sel;

  always_comb begin
    ignored = ((source_ip != primary_server_ip) && (source_ip != backup_server_ip))
           || (view.phase == PH_HDR)
           || !view.header_control[15]
           || view.header_control[9];
    if (ignored)
      verdict = V_IGNORED;
    else if (view.header_control[3:0] != 4'd0)
      verdict = V_SERVERR;
    else
      verdict = view.packet_verdict;
    ttl_sel  = (verdict == V_FOUND) ? view.ttl_accum     : 32'd0;
    addr_sel = (verdict == V_FOUND) ? view.address_accum : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {1'b0, addr_sel, ttl_sel, view.header_control[3:0],
                  view.header_id, verdict};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dns_response_parser_top.sv =====
// DNS reply parser top level: input register, server address registers,
// byte walker and result register. Depends on drp_pkg, drp_parse_core,
// drp_result_reg.
`default_nettype none

// Takes a DNS reply as a stream of UDP payload bytes, one byte per item, with
// the sender address beside each byte, and gives one result item for the
// item that carries tlast: verdict (0 address found, 1 server error, 2 no
// answers, 3 no address record or packet ended early, 4 ignored), query id,
// rcode, and the TTL and IPv4 address of the first answer record whose data
// is four bytes long (zero unless the verdict is 0). Replies from a sender
// other than the primary or backup server, packets under 12 bytes,
// non-responses and truncated replies are ignored. Compression pointers are
// followed only as name terminators; bytes after the answer walk ends are
// ignored. Rate: one byte per clock while no last byte waits for the result
// register. A byte passes through the input register; the parse logic then
// updates the packet state from it and, for a last byte, loads the result
// register that offers the result item. Bytes that are not a packet's last
// keep flowing while a result waits; only a last byte waits for the result
// register to drain. The server addresses are written through the cfg port
// (index 0 primary, index 1 backup); the user must write them only while no
// packet is in flight, which the block itself does not enforce.
module dns_response_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write port
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  // byte stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // {source_ip, pkt_byte}, pkt_byte in [7:0]
  input  wire logic        s_tlast,   // last_byte
  // result stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata    // {address, ttl_seconds, rcode, query_id, verdict}
);
  import drp_pkg::*;

  localparam logic CFG_PRIMARY = 1'b0;
  localparam logic CFG_BACKUP  = 1'b1;

  logic [31:0] primary_server_ip;
  logic [31:0] backup_server_ip;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [31:0] in_src;
  logic        advance;

  parse_view_t view;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_server_ip <= 32'd0;
      backup_server_ip  <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PRIMARY: primary_server_ip <= cfg_data;
        CFG_BACKUP:  backup_server_ip  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A held byte moves on unless it is a last byte facing a full result slot.
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata[7:0];
      in_src  <= s_tdata[39:8];
      in_last <= s_tlast;
    end
  end

  drp_parse_core u_parse (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .last_byte (in_last),
    .pkt_byte  (in_byte),
    .view      (view)
  );

  drp_result_reg u_result (
    .clk               (clk),
    .rst               (rst),
    .load              (advance && in_last),
    .view              (view),
    .source_ip         (in_src),
    .primary_server_ip (primary_server_ip),
    .backup_server_ip  (backup_server_ip),
    .m_tready          (m_tready),
    .m_tvalid          (m_tvalid),
    .m_tdata           (m_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/drp_tb_pkg.sv =====
// Testbench-side definitions for the DNS reply parser bench.
// Config register indexes and the unpacked view of a result item.
// Depends on nothing.
`timescale 1ns / 1ps

package drp_tb_pkg;

  localparam logic REG_PRIMARY = 1'b0;
  localparam logic REG_BACKUP  = 1'b1;

  // One result item as it sits in m_tdata[86:0], bit 87 is padding.
  // Fields from bit 0 up: verdict, query_id, rcode, ttl_seconds, address.
  typedef struct packed {
    logic [31:0] address;
    logic [31:0] ttl_seconds;
    logic [3:0]  rcode;
    logic [15:0] query_id;
    logic [2:0]  verdict;
  } dns_result_t;

endpackage

// ===== tb/drp_checker.sv =====
// Passive checker for dns_response_parser_top: tracks config writes, walks every
// accepted byte through its own parse state and compares each result item.
// Depends on drp_pkg and drp_tb_pkg.
`timescale 1ns / 1ps

module drp_checker
  import drp_pkg::*;
  import drp_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          found
);

  logic [31:0] srv_ip [2];

  // walk state for the packet in flight
  phase_t      walk_phase;
  logic [15:0] byte_idx;
  logic [15:0] hdr_id;
  logic [15:0] hdr_ctl;
  logic [15:0] qd_left;
  logic [15:0] an_left;
  logic [15:0] skip_left;
  logic [2:0]  fld_cnt;
  logic [31:0] ttl_acc;
  logic [15:0] rdlen;
  logic [31:0] addr_acc;
  logic [2:0]  pkt_verdict;

  dns_result_t replies [$];
  dns_result_t got_reply;
  dns_result_t want_reply;

  task automatic clear_walk();
    walk_phase  = PH_HDR;
    byte_idx    = '0;
    hdr_id      = '0;
    hdr_ctl     = '0;
    qd_left     = '0;
    an_left     = '0;
    skip_left   = '0;
    fld_cnt     = '0;
    ttl_acc     = '0;
    rdlen       = '0;
    addr_acc    = '0;
    pkt_verdict = V_NOADDR;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("drp_checker: result %0d %s: got %0h, want %0h", checked, what, got, want);
  endtask

  // Length byte of a name: zero or a pointer ends it, anything else is a label.
  task automatic name_step(input logic [7:0] b, input phase_t label_ph,
                           input phase_t tail_ph);
    if (b == 8'h00) begin
      skip_left  = TAIL_PLAIN;
      walk_phase = tail_ph;
    end else if (b[7:6] == PTR_MARK) begin
      skip_left  = TAIL_PTR;
      walk_phase = tail_ph;
    end else begin
      skip_left  = {8'h00, b};
      walk_phase = label_ph;
    end
  endtask

  task automatic next_answer();
    if (an_left != 0) an_left = an_left - 1'b1;
    walk_phase = (an_left != 0) ? PH_ALAB : PH_DONE;
  endtask

  task automatic walk_byte(input logic [7:0] b);
    case (walk_phase)
      PH_HDR: begin
        case (byte_idx)
          16'd0: hdr_id = {b, 8'h00};
          16'd1: hdr_id[7:0] = b;
          16'd2: hdr_ctl = {b, 8'h00};
          16'd3: hdr_ctl[7:0] = b;
          16'd4: qd_left = {b, 8'h00};
          16'd5: qd_left[7:0] = b;
          16'd6: an_left = {b, 8'h00};
          16'd7: an_left[7:0] = b;
          default: ;
        endcase
        if (byte_idx == 16'(HDR_LEN - 1)) begin
          if (an_left == 0) begin
            pkt_verdict = V_NOANS;
            walk_phase  = PH_DONE;
          end else begin
            walk_phase = (qd_left != 0) ? PH_QLAB : PH_ALAB;
          end
        end
      end
      PH_QLAB: name_step(b, PH_QSKIP, PH_QTAIL);
      PH_QSKIP: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) walk_phase = PH_QLAB;
      end
      PH_QTAIL: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) begin
          qd_left    = qd_left - 1'b1;
          walk_phase = (qd_left != 0) ? PH_QLAB : PH_ALAB;
        end
      end
      PH_ALAB: name_step(b, PH_ASKIP, PH_ATYPE);
      PH_ASKIP: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) walk_phase = PH_ALAB;
      end
      PH_ATYPE: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) begin
          walk_phase = PH_ATTL;
          fld_cnt    = '0;
          ttl_acc    = '0;
        end
      end
      PH_ATTL: begin
        ttl_acc = {ttl_acc[23:0], b};
        fld_cnt = fld_cnt + 1'b1;
        if (fld_cnt >= TTL_BYTES) begin
          walk_phase = PH_ARDLEN;
          fld_cnt    = '0;
          rdlen      = '0;
        end
      end
      PH_ARDLEN: begin
        rdlen   = {rdlen[7:0], b};
        fld_cnt = fld_cnt + 1'b1;
        if (fld_cnt >= RDLEN_BYTES) begin
          fld_cnt = '0;
          if (rdlen == A_RDLEN) begin
            walk_phase = PH_AADDR;
            addr_acc   = '0;
          end else if (rdlen == 0) begin
            next_answer();
          end else begin
            skip_left  = rdlen;
            walk_phase = PH_ARDSKIP;
          end
        end
      end
      PH_AADDR: begin
        addr_acc = {addr_acc[23:0], b};
        fld_cnt  = fld_cnt + 1'b1;
        if (fld_cnt >= ADDR_BYTES) begin
          pkt_verdict = V_FOUND;
          walk_phase  = PH_DONE;
        end
      end
      PH_ARDSKIP: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) next_answer();
      end
      default: ;
    endcase
    if (byte_idx != 16'hFFFF) byte_idx = byte_idx + 1'b1;
  endtask

  // Verdict for the packet that just ended; sender and header checks win.
  task automatic close_packet(input logic [31:0] src);
    dns_result_t r;
    if ((src != srv_ip[REG_PRIMARY] && src != srv_ip[REG_BACKUP]) ||
        walk_phase == PH_HDR || !hdr_ctl[15] || hdr_ctl[9])
      r.verdict = V_IGNORED;
    else if (hdr_ctl[3:0] != 4'h0)
      r.verdict = V_SERVERR;
    else
      r.verdict = pkt_verdict;
    r.query_id    = hdr_id;
    r.rcode       = hdr_ctl[3:0];
    r.ttl_seconds = (r.verdict == V_FOUND) ? ttl_acc : 32'h0;
    r.address     = (r.verdict == V_FOUND) ? addr_acc : 32'h0;
    replies.push_back(r);
    clear_walk();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      srv_ip[REG_PRIMARY] = '0;
      srv_ip[REG_BACKUP]  = '0;
      replies.delete();
      clear_walk();
    end else begin
      if (m_tvalid && m_tready) begin
        got_reply = m_tdata[86:0];
        if (replies.size() == 0) begin
          report_mismatch("unexpected, verdict", 32'(got_reply.verdict), 32'h0);
        end else begin
          want_reply = replies.pop_front();
          if (got_reply.verdict != want_reply.verdict)
            report_mismatch("verdict", 32'(got_reply.verdict), 32'(want_reply.verdict));
          if (got_reply.query_id != want_reply.query_id)
            report_mismatch("query_id", 32'(got_reply.query_id), 32'(want_reply.query_id));
          if (got_reply.rcode != want_reply.rcode)
            report_mismatch("rcode", 32'(got_reply.rcode), 32'(want_reply.rcode));
          if (got_reply.ttl_seconds != want_reply.ttl_seconds)
            report_mismatch("ttl_seconds", got_reply.ttl_seconds, want_reply.ttl_seconds);
          if (got_reply.address != want_reply.address)
            report_mismatch("address", got_reply.address, want_reply.address);
          if (want_reply.verdict == V_FOUND) found++;
          checked++;
        end
      end
      if (cfg_wr_en) srv_ip[cfg_index] = cfg_data;
      if (s_tvalid && s_tready) begin
        walk_byte(s_tdata[7:0]);
        if (s_tlast) close_packet(s_tdata[39:8]);
      end
    end
    pending = replies.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the DNS reply parser bench: clock, reset, packet stimulus and verdict.
// Instantiates dns_response_parser_top and drp_checker; uses drp_pkg, drp_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import drp_tb_pkg::*;

  localparam int LIMIT         = 800_000;  // cycles before the run is declared hung
  localparam int SETTLE_CYCLES = 8;        // idle margin before a config write
  localparam int PHASE_BYTES   = 250;
  localparam int PHASE_PKTS    = 12;
  localparam int LONG_TAIL     = 40;       // trailing bytes after a found record

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // pkt_byte [7:0], source_ip [39:8]
  logic        s_tlast;   // last_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;   // verdict, query_id, rcode, ttl_seconds, address, pad

  int errors;
  int pending;
  int checked;
  int found;

  int cycles;
  int bytes_sent;
  int pkts_sent;
  int settings;

  logic [31:0] prim_ip;
  logic [31:0] back_ip;

  // payload of the packet being built, in wire order
  logic [7:0] pkt [$];

  dns_response_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  drp_checker chk (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked),
    .found    (found)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Gap length: mostly none, often a few cycles, now and then a long stall.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side back-pressure, with long ready stretches mixed in.
  initial begin : sink
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      n = gap_len();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(40, 120)) @(negedge clk);
      else repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge; handshakes are seen on
  // the rising edge.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic lst, input logic [31:0] src);
    s_tdata  <= {src, b};
    s_tlast  <= lst;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Send the built packet; source_ip stays fixed over its bytes.
  task automatic send_packet(input logic [31:0] src, input bit burst);
    for (int i = 0; i < pkt.size(); i++) begin
      if (!burst) idle_gap();
      push_byte(pkt[i], i == pkt.size() - 1, src);
    end
    bytes_sent += pkt.size();
    pkts_sent++;
  endtask

  // Drop valid and wait until every result is out and the pipe is empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Packet builders
  // ---------------------------------------------------------------------------
  task automatic put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  task automatic put_random(input int n);
    repeat (n) pkt.push_back(8'($urandom));
  endtask

  // id, control, qdcount, ancount, then nscount/arcount as one word
  task automatic put_header(input logic [15:0] id, input logic [15:0] ctl,
                            input logic [15:0] qd, input logic [15:0] an,
                            input logic [31:0] rest);
    put16(id);
    put16(ctl);
    put16(qd);
    put16(an);
    put16(rest[31:16]);
    put16(rest[15:0]);
  endtask

  // Labels, then a zero byte or a compression pointer. Rarely a length byte
  // with top bits 01 or 10, which is still just a long label.
  task automatic put_name();
    int labels;
    int len;
    labels = $urandom_range(0, 3);
    repeat (labels) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 6);
      pkt.push_back(8'(len));
      put_random(len);
    end
    if ($urandom_range(0, 2) == 0) begin
      pkt.push_back({2'b11, 6'($urandom)});
      pkt.push_back(8'($urandom));
    end else begin
      pkt.push_back(8'h00);
    end
  endtask

  task automatic put_answer(input bit is_a);
    logic [15:0] len;
    put_name();
    put_random(8);  // type, class, ttl
    if (is_a) begin
      len = 16'd4;
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    len = 16'd0;
        2, 3, 4: len = 16'($urandom_range(1, 3));
        8:       len = 16'd16;
        9:       len = 16'h0104;  // low byte 4, must not count as an address
        default: len = 16'($urandom_range(5, 12));
      endcase
    end
    put16(len);
    put_random(int'(len));
  endtask

  // Mostly well-formed replies with random content; the rest truncated,
  // short or plain noise.
  task automatic build_packet();
    logic [15:0] ctl;
    logic [15:0] qd;
    logic [15:0] an;
    int keep;
    int mode;
    pkt.delete();
    ctl = 16'($urandom);
    ctl[15] = ($urandom_range(0, 9) != 0);
    ctl[9]  = ($urandom_range(0, 11) == 0);
    if ($urandom_range(0, 4) != 0) ctl[3:0] = 4'h0;
    qd = 16'($urandom_range(0, 2));
    an = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom_range(1, 3));
    if ($urandom_range(0, 24) == 0) qd = 16'($urandom);
    if ($urandom_range(0, 24) == 0) an = 16'($urandom);
    put_header(16'($urandom), ctl, qd, an, $urandom);
    repeat ((qd > 2) ? 2 : int'(qd)) begin
      put_name();
      put_random(4);
    end
    repeat ((an > 3) ? 3 : int'(an)) put_answer($urandom_range(0, 2) != 0);
    put_random($urandom_range(0, 3));  // trailing bytes past the walk
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      keep = $urandom_range(1, pkt.size());
      while (pkt.size() > keep) void'(pkt.pop_back());
    end else if (mode == 2) begin
      pkt.delete();
      put_random($urandom_range(1, 40));
    end else if (mode == 3) begin
      pkt.delete();
      put_random($urandom_range(1, 11));
    end
  endtask

  function automatic logic [31:0] pick_source();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r < 6) return prim_ip;
    return back_ip;
  endfunction

  // One server address setting, then random packets until the phase is full, then the long packet if with_long is set.
  task automatic run_phase(input logic [31:0] p, input logic [31:0] b, input bit with_long);
    int nbytes;
    int npkts;
    nbytes = 0;
    npkts  = 0;
    settle();
    write_reg(REG_PRIMARY, p);
    write_reg(REG_BACKUP, b);
    prim_ip = p;
    back_ip = b;
    settings++;
    while (nbytes < PHASE_BYTES || npkts < PHASE_PKTS) begin
      build_packet();
      nbytes += pkt.size();
      npkts++;
      send_packet(pick_source(), $urandom_range(0, 4) == 0);
    end
    if (with_long) begin
      // found record, then a run of trailing bytes that must be ignored
      pkt.delete();
      put_header(16'($urandom), 16'h8180, 16'd1, 16'd1, 32'h0);
      put_name();
      put_random(4);
      put_answer(1'b1);
      put_random(LONG_TAIL);
      send_packet(prim_ip, 1'b1);
    end
  endtask

  initial begin : stimulus
    logic [31:0] same_ip;
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_PRIMARY;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, with both server registers still at their reset value of 0:
    // one-byte short packet, header with all-ones id and nscount/arcount and a
    // server error rcode, and a bare header with no answers.
    pkt.delete();
    pkt.push_back(8'hFF);
    send_packet(32'h0, 1'b0);
    pkt.delete();
    put_header(16'hFFFF, 16'h800F, 16'h0000, 16'h0001, 32'hFFFF_FFFF);
    send_packet(32'h0, 1'b0);
    pkt.delete();
    put_header(16'h0000, 16'h8000, 16'h0000, 16'h0000, 32'h0);
    send_packet(32'h0, 1'b1);

    // Random phases: extreme addresses, both zero, random pair with the long
    // packet, and backup equal to primary.
    run_phase(32'h0A00_0035, 32'hFFFF_FFFF, 1'b0);
    run_phase(32'h0, 32'h0, 1'b0);
    run_phase($urandom, $urandom, 1'b1);
    same_ip = $urandom;
    run_phase(same_ip, same_ip, 1'b0);
    settle();

    $display("tb_top: %0d bytes in %0d packets under %0d server address settings",
             bytes_sent, pkts_sent, settings);
    $display("tb_top: %0d results compared, %0d of them with an address found",
             checked, found);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/drp_pkg.sv
rtl/core/drp_parse_core.sv
rtl/core/drp_result_reg.sv
rtl/core/dns_response_parser_top.sv
tb/drp_tb_pkg.sv
tb/drp_checker.sv
tb/tb_top.sv
